// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/brs_pkg.sv
package brs_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int LEVEL_W     = 7;
    localparam int TIMEOUT_W   = 22;
    localparam int MAXRET_W    = 4;
    localparam int RETRY_W     = 5;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [LEVEL_W-1:0]   LOW_THR_RST    = 7'd20;
    localparam logic [LEVEL_W-1:0]   RESUME_THR_RST = 7'd80;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 22'd60000;
    localparam logic [MAXRET_W-1:0]  MAX_RETRY_RST  = 4'd3;
    localparam logic [RETRY_W-1:0]   RETRY_CAP      = 5'd16;

    typedef enum logic [2:0] {
        MODE_WORK    = 3'd0,
        MODE_LOW     = 3'd1,
        MODE_TRAVEL  = 3'd2,
        MODE_ARRIVED = 3'd3,
        MODE_DOCK    = 3'd4,
        MODE_CHARGE  = 3'd5,
        MODE_RESUME  = 3'd6,
        MODE_ERROR   = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        REQ_NONE   = 3'd0,
        REQ_START  = 3'd1,
        REQ_STOP   = 3'd2,
        REQ_TRAVEL = 3'd3,
        REQ_CHON   = 3'd4,
        REQ_CHOFF  = 3'd5,
        REQ_RESUME = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        REG_LOW_THR    = 2'd0,
        REG_RESUME_THR = 2'd1,
        REG_TIMEOUT    = 2'd2,
        REG_MAX_RETRY  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   low_threshold;
        logic [LEVEL_W-1:0]   resume_threshold;
        logic [TIMEOUT_W-1:0] travel_timeout;
        logic [MAXRET_W-1:0]  max_retries;
    } cfg_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] now_time;
        logic [LEVEL_W-1:0]    level;
        logic                  level_valid;
        logic                  start_work_ok;
        logic                  stop_work_ok;
        logic                  travel_req_ok;
        logic                  travel_done;
        logic                  dock_done;
        logic                  charge_on_ok;
        logic                  charge_off_ok;
        logic                  resume_ok;
    } tick_t;

    typedef struct packed {
        mode_t              mode;
        req_t               request;
        logic [RETRY_W-1:0] retries_used;
    } result_t;

endpackage

// File: hw/rtl/brs_cfg_regs.sv
module brs_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [brs_pkg::ADDR_W-1:0] paddr,
    input  logic [brs_pkg::DATA_W-1:0] pwdata,
    output logic [brs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output brs_pkg::cfg_t              cfg
);

    brs_pkg::cfg_t    cfg_reg;
    brs_pkg::cfg_t    cfg_next;
    brs_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = brs_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                brs_pkg::REG_LOW_THR:
                    cfg_next.low_threshold = pwdata[brs_pkg::LEVEL_W-1:0];
                brs_pkg::REG_RESUME_THR:
                    cfg_next.resume_threshold = pwdata[brs_pkg::LEVEL_W-1:0];
                brs_pkg::REG_TIMEOUT:
                    cfg_next.travel_timeout = pwdata[brs_pkg::TIMEOUT_W-1:0];
                brs_pkg::REG_MAX_RETRY:
                    cfg_next.max_retries = pwdata[brs_pkg::MAXRET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            brs_pkg::REG_LOW_THR:
                prdata = brs_pkg::DATA_W'(cfg_reg.low_threshold);
            brs_pkg::REG_RESUME_THR:
                prdata = brs_pkg::DATA_W'(cfg_reg.resume_threshold);
            brs_pkg::REG_TIMEOUT:
                prdata = brs_pkg::DATA_W'(cfg_reg.travel_timeout);
            brs_pkg::REG_MAX_RETRY:
                prdata = brs_pkg::DATA_W'(cfg_reg.max_retries);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold    <= brs_pkg::LOW_THR_RST;
            cfg_reg.resume_threshold <= brs_pkg::RESUME_THR_RST;
            cfg_reg.travel_timeout   <= brs_pkg::TIMEOUT_RST;
            cfg_reg.max_retries      <= brs_pkg::MAX_RETRY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/brs_seq_core.sv
`include "assert_macros.svh"

module brs_seq_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  brs_pkg::tick_t   tick,
    input  brs_pkg::cfg_t    cfg,
    output brs_pkg::result_t result
);

    brs_pkg::mode_t                  mode_reg, mode_next;
    logic                            work_started_reg, work_started_next;
    logic [brs_pkg::RETRY_W-1:0]     retry_count_reg, retry_count_next;
    logic [brs_pkg::TIME_WIDTH-1:0]  travel_start_reg, travel_start_next;
    brs_pkg::req_t                   req;

    logic [brs_pkg::TIME_WIDTH-1:0]  elapsed;
    logic [brs_pkg::TIME_WIDTH-1:0]  timeout_ext;
    logic                            timed_out;
    logic [brs_pkg::RETRY_W-1:0]     retry_inc;
    logic                            retry_left;

    // wrapping difference handles counter rollover
    assign elapsed     = tick.now_time - travel_start_reg;
    assign timeout_ext = brs_pkg::TIME_WIDTH'(cfg.travel_timeout);
    assign timed_out   = elapsed > timeout_ext;
    assign retry_inc   = (retry_count_reg < brs_pkg::RETRY_CAP) ?
                         retry_count_reg + 5'd1 : retry_count_reg;
    assign retry_left  = retry_inc <= brs_pkg::RETRY_W'(cfg.max_retries);

    always_comb
    begin
        mode_next         = mode_reg;
        work_started_next = work_started_reg;
        retry_count_next  = retry_count_reg;
        travel_start_next = travel_start_reg;
        req               = brs_pkg::REQ_NONE;
        unique case (mode_reg)
            brs_pkg::MODE_WORK:
            begin
                if (!work_started_reg)
                begin
                    req               = brs_pkg::REQ_START;
                    work_started_next = tick.start_work_ok;
                end
                if (!work_started_reg && !tick.start_work_ok)
                    mode_next = brs_pkg::MODE_ERROR;
                else if (tick.level_valid && tick.level <= cfg.low_threshold)
                    mode_next = brs_pkg::MODE_LOW;
            end
            brs_pkg::MODE_LOW:
            begin
                if (!tick.stop_work_ok)
                begin
                    req       = brs_pkg::REQ_STOP;
                    mode_next = brs_pkg::MODE_ERROR;
                end
                else
                begin
                    // stop succeeded, travel issued in the same tick
                    req               = brs_pkg::REQ_TRAVEL;
                    travel_start_next = tick.now_time;
                    mode_next         = tick.travel_req_ok ? brs_pkg::MODE_TRAVEL
                                                           : brs_pkg::MODE_ERROR;
                end
            end
            brs_pkg::MODE_TRAVEL:
            begin
                if (timed_out)
                begin
                    retry_count_next = retry_inc;
                    if (retry_left)
                    begin
                        travel_start_next = tick.now_time;
                        req               = brs_pkg::REQ_TRAVEL;
                    end
                    else
                        mode_next = brs_pkg::MODE_ERROR;
                end
                else if (tick.travel_done)
                begin
                    retry_count_next = '0;
                    mode_next        = brs_pkg::MODE_ARRIVED;
                end
            end
            brs_pkg::MODE_ARRIVED:
                mode_next = brs_pkg::MODE_DOCK;
            brs_pkg::MODE_DOCK:
            begin
                if (tick.dock_done)
                begin
                    req       = brs_pkg::REQ_CHON;
                    mode_next = tick.charge_on_ok ? brs_pkg::MODE_CHARGE
                                                  : brs_pkg::MODE_ERROR;
                end
            end
            brs_pkg::MODE_CHARGE:
            begin
                if (tick.level_valid && tick.level >= cfg.resume_threshold)
                begin
                    req       = brs_pkg::REQ_CHOFF;
                    mode_next = tick.charge_off_ok ? brs_pkg::MODE_RESUME
                                                   : brs_pkg::MODE_ERROR;
                end
            end
            brs_pkg::MODE_RESUME:
            begin
                req = brs_pkg::REQ_RESUME;
                if (tick.resume_ok)
                begin
                    work_started_next = 1'b1;
                    mode_next         = brs_pkg::MODE_WORK;
                end
                else
                    mode_next = brs_pkg::MODE_ERROR;
            end
            brs_pkg::MODE_ERROR: ;
            default: ;
        endcase
    end

    assign result.mode         = mode_next;
    assign result.request      = req;
    assign result.retries_used = retry_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= brs_pkg::MODE_WORK;
            work_started_reg <= 1'b0;
            retry_count_reg  <= '0;
            travel_start_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg         <= mode_next;
            work_started_reg <= work_started_next;
            retry_count_reg  <= retry_count_next;
            travel_start_reg <= travel_start_next;
        end
    end

    `ASSERT_NEXT(a_error_sticky, clk, rst_n, mode_reg == brs_pkg::MODE_ERROR, mode_reg == brs_pkg::MODE_ERROR)
    `ASSERT_ALWAYS(a_retry_cap, clk, rst_n, retry_count_reg <= brs_pkg::RETRY_CAP)
    `ASSERT_NEXT(a_arrive_dock, clk, rst_n, step_en && mode_reg == brs_pkg::MODE_ARRIVED, mode_reg == brs_pkg::MODE_DOCK)
    `ASSERT_NEXT(a_hold_idle, clk, rst_n, !step_en, $stable(mode_reg) && $stable(retry_count_reg))

endmodule

// File: hw/rtl/battery_recharge_sequencer.sv
// Battery recharge sequencer.
// Input channel (in_valid / in_stall): one update item per tick carrying the
// timestamp, battery level with its valid flag and the answers to whatever
// the current mode asks. Output channel (out_valid / out_stall): one result
// item per input item with the new mode, the request issued in that tick and
// the travel retry count.
// Path from input accept to result valid: input register, then next-state
// logic into the result register. Throughput: one item per cycle while
// out_stall is low, set by the next-state step of the mode register.
// Stalls: while a result waits under out_stall, one more item is still taken
// into the input register; in_stall rises only when both registers are full.
// Reset (rst_n low, async): mode goes to working with work not yet started,
// retry count and travel timer clear, thresholds 20/80, timeout 60000 ms,
// 3 retries. Both channels come out of reset empty.
// Configuration: APB registers at 0x0 low threshold, 0x4 resume threshold,
// 0x8 travel timeout, 0xC max retries; write only while the block is idle.
module battery_recharge_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brs_pkg::ADDR_W-1:0]      paddr,
    input  logic [brs_pkg::DATA_W-1:0]      pwdata,
    output logic [brs_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    // input items
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [brs_pkg::TIME_WIDTH-1:0]  now_time,
    input  logic [brs_pkg::LEVEL_W-1:0]     level,
    input  logic                            level_valid,
    input  logic                            start_work_ok,
    input  logic                            stop_work_ok,
    input  logic                            travel_req_ok,
    input  logic                            travel_done,
    input  logic                            dock_done,
    input  logic                            charge_on_ok,
    input  logic                            charge_off_ok,
    input  logic                            resume_ok,
    // result items
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      mode,
    output logic [2:0]                      request,
    output logic [brs_pkg::RETRY_W-1:0]     retries_used
);

    brs_pkg::cfg_t    cfg;
    brs_pkg::tick_t   tick_reg;
    brs_pkg::result_t step_res;
    brs_pkg::result_t res_reg;
    logic             item_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             step_en;
    logic             in_take;

    brs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result register free or being drained this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign step_en  = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!in_stall)
            item_valid_reg <= in_valid;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg.now_time      <= now_time;
            tick_reg.level         <= level;
            tick_reg.level_valid   <= level_valid;
            tick_reg.start_work_ok <= start_work_ok;
            tick_reg.stop_work_ok  <= stop_work_ok;
            tick_reg.travel_req_ok <= travel_req_ok;
            tick_reg.travel_done   <= travel_done;
            tick_reg.dock_done     <= dock_done;
            tick_reg.charge_on_ok  <= charge_on_ok;
            tick_reg.charge_off_ok <= charge_off_ok;
            tick_reg.resume_ok     <= resume_ok;
        end
    end

    brs_seq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .tick    (tick_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign mode         = res_reg.mode;
    assign request      = res_reg.request;
    assign retries_used = res_reg.retries_used;

endmodule
